### rtl/core/cfevc_pkg.sv
`default_nettype none

package cfevc_pkg;

	localparam int CORDIC_STEPS = 30;
	localparam int STEP_W       = 5;
	localparam int ATAN_W       = 30;
	localparam int LOD_RESET    = 8;
	localparam int REG_IDX_W    = 1;

	localparam logic [ATAN_W-1:0] ATAN_PI4 = 30'd843314857;

	localparam logic [REG_IDX_W-1:0] REG_LOD  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_FACE = 1'b1;

	localparam logic [2:0] FACE_BACK   = 3'd0;
	localparam logic [2:0] FACE_RIGHT  = 3'd1;
	localparam logic [2:0] FACE_FRONT  = 3'd2;
	localparam logic [2:0] FACE_LEFT   = 3'd3;
	localparam logic [2:0] FACE_TOP    = 3'd4;
	localparam logic [2:0] FACE_BOTTOM = 3'd5;

	typedef enum logic [2:0] {
		FILL_LOAD,
		FILL_ZDIV,
		FILL_ROT,
		FILL_CHECK,
		FILL_QDIV,
		FILL_WRITE,
		FILL_IDLE
	} fill_state_t;

	// atan(2^-n) in Q2.30
	function automatic logic [ATAN_W-1:0] atan_q30(input logic [STEP_W-1:0] n);
		logic [ATAN_W-1:0] r;
		unique case (n)
			5'd0:    r = 30'd843314857;
			5'd1:    r = 30'd497837829;
			5'd2:    r = 30'd263043837;
			5'd3:    r = 30'd133525159;
			5'd4:    r = 30'd67021687;
			5'd5:    r = 30'd33543516;
			5'd6:    r = 30'd16775851;
			5'd7:    r = 30'd8388437;
			5'd8:    r = 30'd4194283;
			5'd9:    r = 30'd2097149;
			5'd10:   r = 30'd1048576;
			5'd11:   r = 30'd524288;
			5'd12:   r = 30'd262144;
			5'd13:   r = 30'd131072;
			5'd14:   r = 30'd65536;
			5'd15:   r = 30'd32768;
			5'd16:   r = 30'd16384;
			5'd17:   r = 30'd8192;
			5'd18:   r = 30'd4096;
			5'd19:   r = 30'd2048;
			5'd20:   r = 30'd1024;
			5'd21:   r = 30'd512;
			5'd22:   r = 30'd256;
			5'd23:   r = 30'd128;
			5'd24:   r = 30'd64;
			5'd25:   r = 30'd32;
			5'd26:   r = 30'd16;
			5'd27:   r = 30'd8;
			5'd28:   r = 30'd4;
			5'd29:   r = 30'd2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/cfevc_ram.sv
`default_nettype none

module cfevc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/cube_face_equiangular_vertex_core.sv
// Equi-angular cube face vertex generator.
//
// Slave stream s_*: one item is a grid point, s_tdata = {col_index, row_index}.
// Master stream m_*: one item is a vertex, m_tdata = {tex_v, tex_u, pos_z, pos_y,
// pos_x}, m_tuser = uv_valid. All values signed fixed point, FRAC_BITS fraction bits.
// Configuration: cfg_we with cfg_index 0 writes lod_level, index 1 writes face_select.
//
// Tangents of the grid angles live in two copies of a table in block RAM, one read
// port per grid axis, indexed by |2k - lod|. A sequencer builds the table with one
// shared restoring divider and a 30-step CORDIC, filling its lod_level+1 entries in turn.
// The build runs after reset and after each lod_level write; s_tready stays low until
// it is done.
//
// Once built, one item is accepted per cycle unless the output stalls; a vertex goes
// through the RAM read, then the output register, to m_tvalid. When m_tready is low
// a full output register and the RAM stage hold; s_tready drops once both are full.
`default_nettype none

module cube_face_equiangular_vertex_core
	import cfevc_pkg::*;
#(
	parameter int INDEX_BITS = 8,
	parameter int FRAC_BITS  = 14,
	localparam int CFG_W      = (INDEX_BITS > 3) ? INDEX_BITS : 3,
	localparam int OUT_W      = FRAC_BITS + 2,
	localparam int IN_DATA_W  = ((2 * INDEX_BITS + 7) / 8) * 8,
	localparam int OUT_DATA_W = ((5 * OUT_W + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [REG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // row_index, col_index
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [OUT_DATA_W-1:0] m_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
	output logic                       m_tuser    // uv_valid
);

	localparam int TAN_W  = FRAC_BITS + 1;
	localparam int NUM_W  = FRAC_BITS + 34;
	localparam int DEN_W  = 32;
	localparam int XY_W   = 33;
	localparam int Z_W    = 32;
	localparam int DEPTH  = 1 << INDEX_BITS;
	localparam int NCNT_W = $clog2(NUM_W + 1);

	localparam logic [TAN_W-1:0]       ONE_Q   = TAN_W'(1) << FRAC_BITS;
	localparam logic signed [OUT_W-1:0] ONE_S  = OUT_W'(1) << FRAC_BITS;
	localparam logic signed [OUT_W-1:0] MONE_S = -(OUT_W'(1) << FRAC_BITS);
	localparam logic signed [XY_W-1:0]  X_INIT = XY_W'(1) << 30;

	function automatic logic [INDEX_BITS:0] grid_mag(input logic [INDEX_BITS-1:0] k,
			input logic [INDEX_BITS-1:0] lod);
		logic [INDEX_BITS-1:0] ks;
		logic [INDEX_BITS:0]   twice;
		logic [INDEX_BITS:0]   lod_e;
		logic [INDEX_BITS:0]   diff;
		logic                  neg;
		ks    = (k > lod) ? lod : k;
		twice = {ks, 1'b0};
		lod_e = {1'b0, lod};
		neg   = twice < lod_e;
		diff  = neg ? (lod_e - twice) : (twice - lod_e);
		return {neg, diff[INDEX_BITS-1:0]};
	endfunction

	function automatic logic signed [OUT_W-1:0] half_map(input logic signed [OUT_W-1:0] t);
		logic signed [OUT_W:0] sum;
		sum = {t[OUT_W-1], t} + {ONE_S[OUT_W-1], ONE_S};
		return sum[OUT_W:1];
	endfunction

	logic [INDEX_BITS-1:0] lod_q;
	logic [2:0]            face_q;

	fill_state_t state_q, state_d;
	logic [INDEX_BITS-1:0] mag_q;
	logic [STEP_W-1:0]     step_q;
	logic [NCNT_W-1:0]     div_cnt_q;

	logic [NUM_W-1:0]      div_num_q;
	logic [DEN_W-1:0]      div_den_q;
	logic [DEN_W-1:0]      div_rem_q;
	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]  z_q;
	logic [TAN_W-1:0]       res_q;

	logic [DEN_W:0]        div_trial;
	logic                  div_ge;
	logic [DEN_W:0]        div_diff;
	logic [DEN_W-1:0]      div_rem_next;
	logic [NUM_W-1:0]      div_quot_next;
	logic                  div_last;
	logic                  cord_last;
	logic signed [XY_W-1:0] cord_dx, cord_dy;
	logic signed [Z_W-1:0]  cord_atan;
	logic                  lod_write;
	logic                  ram_we;

	assign lod_write = cfg_we && (cfg_index == REG_LOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lod_q  <= INDEX_BITS'(LOD_RESET);
			face_q <= FACE_BACK;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOD:  lod_q  <= cfg_data[INDEX_BITS-1:0];
				REG_FACE: face_q <= cfg_data[2:0];
				default:  ;
			endcase
		end
	end

	assign div_trial     = {div_rem_q, div_num_q[NUM_W-1]};
	assign div_ge        = div_trial >= {1'b0, div_den_q};
	assign div_diff      = div_ge ? (div_trial - {1'b0, div_den_q}) : div_trial;
	assign div_rem_next  = div_diff[DEN_W-1:0];
	assign div_quot_next = {div_num_q[NUM_W-2:0], div_ge};
	assign div_last      = div_cnt_q == NCNT_W'(NUM_W - 1);

	assign cord_dx   = y_q >>> step_q;
	assign cord_dy   = x_q >>> step_q;
	assign cord_atan = signed'(Z_W'(atan_q30(step_q)));
	assign cord_last = step_q == STEP_W'(CORDIC_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FILL_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ram_we  = 1'b0;
		unique case (state_q)
			FILL_LOAD: begin
				state_d = (lod_q == '0) ? FILL_WRITE : FILL_ZDIV;
			end
			FILL_ZDIV: begin
				if (div_last) begin
					state_d = FILL_ROT;
				end
			end
			FILL_ROT: begin
				if (cord_last) begin
					state_d = FILL_CHECK;
				end
			end
			FILL_CHECK: begin
				if (x_q[XY_W-1] || x_q == '0 || y_q[XY_W-1]) begin
					state_d = FILL_WRITE;
				end else begin
					state_d = FILL_QDIV;
				end
			end
			FILL_QDIV: begin
				if (div_last) begin
					state_d = FILL_WRITE;
				end
			end
			FILL_WRITE: begin
				ram_we  = 1'b1;
				state_d = (mag_q == lod_q) ? FILL_IDLE : FILL_LOAD;
			end
			FILL_IDLE: begin
				state_d = FILL_IDLE;
			end
			default: begin
				state_d = FILL_LOAD;
			end
		endcase
		if (lod_write) begin
			state_d = FILL_LOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q     <= '0;
			step_q    <= '0;
			div_cnt_q <= '0;
		end else begin
			if (lod_write) begin
				mag_q <= '0;
			end else if (state_q == FILL_WRITE && mag_q != lod_q) begin
				mag_q <= mag_q + 1'b1;
			end
			if (state_q == FILL_ZDIV && div_last) begin
				step_q <= '0;
			end else if (state_q == FILL_ROT) begin
				step_q <= step_q + 1'b1;
			end
			if (state_q == FILL_LOAD || state_q == FILL_CHECK) begin
				div_cnt_q <= '0;
			end else if (state_q == FILL_ZDIV || state_q == FILL_QDIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			FILL_LOAD: begin
				div_num_q <= NUM_W'(mag_q) * NUM_W'(ATAN_PI4) + NUM_W'(lod_q >> 1);
				div_den_q <= DEN_W'(lod_q);
				div_rem_q <= '0;
				res_q     <= '0;
			end
			FILL_ZDIV: begin
				div_num_q <= div_quot_next;
				div_rem_q <= div_rem_next;
				if (div_last) begin
					z_q <= signed'(div_quot_next[Z_W-1:0]);
					x_q <= X_INIT;
					y_q <= '0;
				end
			end
			FILL_ROT: begin
				if (!z_q[Z_W-1]) begin
					x_q <= x_q - cord_dx;
					y_q <= y_q + cord_dy;
					z_q <= z_q - cord_atan;
				end else begin
					x_q <= x_q + cord_dx;
					y_q <= y_q - cord_dy;
					z_q <= z_q + cord_atan;
				end
			end
			FILL_CHECK: begin
				if (x_q[XY_W-1] || x_q == '0) begin
					res_q <= ONE_Q;
				end else if (y_q[XY_W-1]) begin
					res_q <= '0;
				end
				div_num_q <= (NUM_W'(y_q[XY_W-2:0]) << FRAC_BITS) + NUM_W'(x_q[XY_W-1:1]);
				div_den_q <= x_q[DEN_W-1:0];
				div_rem_q <= '0;
			end
			FILL_QDIV: begin
				div_num_q <= div_quot_next;
				div_rem_q <= div_rem_next;
				if (div_last) begin
					res_q <= (div_quot_next > NUM_W'(ONE_Q)) ? ONE_Q
						: div_quot_next[TAN_W-1:0];
				end
			end
			FILL_WRITE: ;
			FILL_IDLE: ;
			default: ;
		endcase
	end

	logic                  valid_s1;
	logic                  neg_row_s1, neg_col_s1;
	logic [2:0]            face_s1;
	logic                  out_valid_q;
	logic                  pipe_en;
	logic                  s_accept;
	logic [INDEX_BITS:0]   row_gm, col_gm;
	logic [TAN_W-1:0]      row_tan, col_tan;

	assign pipe_en  = !out_valid_q || m_tready;
	assign s_tready = (state_q == FILL_IDLE) && (!valid_s1 || pipe_en);
	assign s_accept = s_tvalid && s_tready;

	assign row_gm = grid_mag(s_tdata[INDEX_BITS-1:0], lod_q);
	assign col_gm = grid_mag(s_tdata[2*INDEX_BITS-1:INDEX_BITS], lod_q);

	cfevc_ram #(
		.WIDTH (TAN_W),
		.DEPTH (DEPTH)
	) u_row_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (mag_q),
		.wdata (res_q),
		.re    (s_accept),
		.raddr (row_gm[INDEX_BITS-1:0]),
		.rdata (row_tan)
	);

	cfevc_ram #(
		.WIDTH (TAN_W),
		.DEPTH (DEPTH)
	) u_col_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (mag_q),
		.wdata (res_q),
		.re    (s_accept),
		.raddr (col_gm[INDEX_BITS-1:0]),
		.rdata (col_tan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (pipe_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			neg_row_s1 <= row_gm[INDEX_BITS];
			neg_col_s1 <= col_gm[INDEX_BITS];
			face_s1    <= face_q;
		end
	end

	logic signed [OUT_W-1:0] a_pos, b_pos, a_v, b_v;
	logic signed [OUT_W-1:0] px_d, py_d, pz_d, tu_d, tv_d;
	logic                    uv_d;
	logic signed [OUT_W-1:0] pos_x_q, pos_y_q, pos_z_q, tex_u_q, tex_v_q;
	logic                    uv_valid_q;

	assign a_pos = signed'(OUT_W'(row_tan));
	assign b_pos = signed'(OUT_W'(col_tan));
	assign a_v   = neg_row_s1 ? -a_pos : a_pos;
	assign b_v   = neg_col_s1 ? -b_pos : b_pos;

	always_comb begin
		px_d = '0;
		py_d = '0;
		pz_d = '0;
		tu_d = '0;
		tv_d = '0;
		uv_d = 1'b1;
		unique case (face_s1)
			FACE_BACK: begin
				px_d = -a_v;
				py_d = b_v;
				pz_d = ONE_S;
				tu_d = -half_map(-a_v);
				tv_d = half_map(b_v);
			end
			FACE_RIGHT: begin
				px_d = ONE_S;
				py_d = -b_v;
				pz_d = -a_v;
				tu_d = half_map(-a_v);
				tv_d = half_map(-b_v);
			end
			FACE_FRONT: begin
				px_d = a_v;
				py_d = b_v;
				pz_d = MONE_S;
				tu_d = half_map(a_v);
				tv_d = half_map(b_v);
			end
			FACE_LEFT: begin
				px_d = MONE_S;
				py_d = a_v;
				pz_d = -b_v;
				tu_d = -half_map(-b_v);
				tv_d = half_map(a_v);
			end
			FACE_TOP: begin
				px_d = -a_v;
				py_d = ONE_S;
				pz_d = -b_v;
				tu_d = half_map(-b_v);
				tv_d = -half_map(-a_v);
			end
			FACE_BOTTOM: begin
				px_d = -a_v;
				py_d = MONE_S;
				pz_d = b_v;
				uv_d = 1'b0;
			end
			default: begin
				uv_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pipe_en) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en && valid_s1) begin
			pos_x_q    <= px_d;
			pos_y_q    <= py_d;
			pos_z_q    <= pz_d;
			tex_u_q    <= tu_d;
			tex_v_q    <= tv_d;
			uv_valid_q <= uv_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({tex_v_q, tex_u_q, pos_z_q, pos_y_q, pos_x_q});
	assign m_tuser  = uv_valid_q;

endmodule

`default_nettype wire

### rtl/core/cfevc_checker.sv
`default_nettype none

module cfevc_checker #(
	parameter int FRAC_BITS = 14,
	localparam int OUT_W      = FRAC_BITS + 2,
	localparam int OUT_DATA_W = ((5 * OUT_W + 7) / 8) * 8
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic                  m_tuser
);

	localparam logic signed [OUT_W-1:0] ONE_S  = OUT_W'(1) << FRAC_BITS;
	localparam logic signed [OUT_W-1:0] MONE_S = -(OUT_W'(1) << FRAC_BITS);

	logic signed [OUT_W-1:0] pos_x, pos_y, pos_z, tex_u, tex_v;

	assign pos_x = m_tdata[OUT_W-1:0];
	assign pos_y = m_tdata[2*OUT_W-1:OUT_W];
	assign pos_z = m_tdata[3*OUT_W-1:2*OUT_W];
	assign tex_u = m_tdata[4*OUT_W-1:3*OUT_W];
	assign tex_v = m_tdata[5*OUT_W-1:4*OUT_W];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled item changed");

	a_build_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !s_tready && !m_tvalid)
		else $error("item taken before tangent table built");

	a_no_uv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> tex_u == '0 && tex_v == '0)
		else $error("texture set without uv_valid");

	a_face_axis: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> pos_x == ONE_S || pos_x == MONE_S || pos_y == ONE_S
			|| pos_y == MONE_S || pos_z == ONE_S || pos_z == MONE_S)
		else $error("no axis fixed at unit on a textured face");

endmodule

bind cube_face_equiangular_vertex_core cfevc_checker #(
	.FRAC_BITS (FRAC_BITS)
) u_cfevc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

### tb/testbench.sv
`default_nettype none

module testbench;
	import cfevc_pkg::*;

	localparam int ONE_Q = 16384;
	localparam int RANDOM_ITEMS = 1700;
	localparam int LONG_HOLD = 300;
	localparam int IDLE_LIMIT = 150000;
	localparam logic [2:0] FACE_SPARE_6 = 3'd6;
	localparam logic [2:0] FACE_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] pos_z;
		logic [15:0] tex_u;
		logic [15:0] tex_v;
		logic        uv_valid;
	} grid_vertex_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [15:0]          s_tdata;   // row_index, col_index
	logic                 m_tvalid;
	logic                 m_tready;
	logic [79:0]          m_tdata;   // pos_x, pos_y, pos_z, tex_u, tex_v
	logic                 m_tuser;   // uv_valid

	cube_face_equiangular_vertex_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	grid_vertex_t expected_vertices[$];
	logic [7:0]  lod_setting;
	logic [2:0]  face_setting;
	int          mismatch_count;
	int          burst_left;
	bit          sender_steady;
	int          hold_ticket;
	int          hold_seen;
	int          hold_left;
	int          ready_mode;
	int          ready_mode_left;
	int          idle_cycles;

	always #10 clk = ~clk;

	// atan(2^-n) in Q2.30; below 2^-10 it equals 2^-n to this precision
	function automatic logic [63:0] atan_pow2(input int n);
		case (n)
			0: return 64'd843314857;
			1: return 64'd497837829;
			2: return 64'd263043837;
			3: return 64'd133525159;
			4: return 64'd67021687;
			5: return 64'd33543516;
			6: return 64'd16775851;
			7: return 64'd8388437;
			8: return 64'd4194283;
			9: return 64'd2097149;
			default: return 64'd1 << (30 - n);
		endcase
	endfunction

	function automatic int tan_magnitude(input logic [63:0] mag, input logic [63:0] lod);
		logic signed [63:0] x, y, z, dx, dy;
		logic [63:0] ay, q;
		int n;
		if (lod == 0)
			return 0;
		x = 64'sd1 <<< 30;
		y = '0;
		z = (mag * atan_pow2(0) + lod / 2) / lod;
		for (n = 0; n < 30; n++) begin
			dx = y >>> n;
			dy = x >>> n;
			if (!z[63]) begin
				x = x - dx;
				y = y + dy;
				z = z - atan_pow2(n);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + atan_pow2(n);
			end
		end
		if (x[63] || x == 0)
			return ONE_Q;
		if (y[63])
			return 0;
		ay = y & 64'hFF_FFFF_FFFF;
		q = ((ay << 14) + ($unsigned(x) >> 1)) / $unsigned(x);
		if (q > ONE_Q)
			q = ONE_Q;
		return int'(q);
	endfunction

	function automatic int grid_tangent(input logic [7:0] k, input logic [7:0] lod);
		logic [63:0] twice;
		twice = 64'(k) * 2;
		if (twice >= lod)
			return tan_magnitude(twice - lod, lod);
		return -tan_magnitude(lod - twice, lod);
	endfunction

	function automatic int half_map(input int t);
		return (t + ONE_Q) >>> 1;
	endfunction

	function automatic grid_vertex_t predict_vertex(input logic [7:0] row,
			input logic [7:0] col);
		grid_vertex_t v;
		logic [7:0] r, c;
		int a, b;
		r = (row > lod_setting) ? lod_setting : row;
		c = (col > lod_setting) ? lod_setting : col;
		a = grid_tangent(r, lod_setting);
		b = grid_tangent(c, lod_setting);
		v = '0;
		v.uv_valid = 1'b1;
		case (face_setting)
			FACE_BACK: begin
				v.pos_x = 16'(-a);
				v.pos_y = 16'(b);
				v.pos_z = 16'(ONE_Q);
				v.tex_u = 16'(-half_map(-a));
				v.tex_v = 16'(half_map(b));
			end
			FACE_RIGHT: begin
				v.pos_x = 16'(ONE_Q);
				v.pos_y = 16'(-b);
				v.pos_z = 16'(-a);
				v.tex_u = 16'(half_map(-a));
				v.tex_v = 16'(half_map(-b));
			end
			FACE_FRONT: begin
				v.pos_x = 16'(a);
				v.pos_y = 16'(b);
				v.pos_z = 16'(-ONE_Q);
				v.tex_u = 16'(half_map(a));
				v.tex_v = 16'(half_map(b));
			end
			FACE_LEFT: begin
				v.pos_x = 16'(-ONE_Q);
				v.pos_y = 16'(a);
				v.pos_z = 16'(-b);
				v.tex_u = 16'(-half_map(-b));
				v.tex_v = 16'(half_map(a));
			end
			FACE_TOP: begin
				v.pos_x = 16'(-a);
				v.pos_y = 16'(ONE_Q);
				v.pos_z = 16'(-b);
				v.tex_u = 16'(half_map(-b));
				v.tex_v = 16'(-half_map(-a));
			end
			FACE_BOTTOM: begin
				v.pos_x = 16'(-a);
				v.pos_y = 16'(-ONE_Q);
				v.pos_z = 16'(b);
				v.uv_valid = 1'b0;
			end
			default: begin
				v.uv_valid = 1'b0;
			end
		endcase
		return v;
	endfunction

	function automatic logic [7:0] random_index(input logic [7:0] lod);
		if ($urandom_range(0, 9) < 7)
			return 8'($urandom_range(0, lod));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic write_reg(input logic [REG_IDX_W-1:0] index, input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == REG_LOD)
			lod_setting = value;
		else
			face_setting = value[2:0];
		@(posedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_vertices.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [7:0] lod, input logic [2:0] face,
			input logic [4:0] upper);
		while (!s_tready) @(posedge clk);
		write_reg(REG_FACE, {upper, face});
		write_reg(REG_LOD, lod);
	endtask

	task automatic send_point(input logic [7:0] row, input logic [7:0] col);
		int gap;
		s_tdata  <= {col, row};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		expected_vertices.push_back(predict_vertex(row, col));
		if (!sender_steady) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(0, 24);
				gap = $urandom_range(1, 8);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left = burst_left - 1;
			end
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		grid_vertex_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_vertices.size() == 0) begin
				$error("vertex with no pending grid point: tdata %h", m_tdata);
				mismatch_count++;
			end else begin
				want = expected_vertices.pop_front();
				check_field("pos_x", want.pos_x, m_tdata[15:0]);
				check_field("pos_y", want.pos_y, m_tdata[31:16]);
				check_field("pos_z", want.pos_z, m_tdata[47:32]);
				check_field("tex_u", want.tex_u, m_tdata[63:48]);
				check_field("tex_v", want.tex_v, m_tdata[79:64]);
				check_field("uv_valid", {15'd0, want.uv_valid}, {15'd0, m_tuser});
			end
		end
	end

	always @(posedge clk) begin
		if (hold_ticket != hold_seen) begin
			hold_seen <= hold_ticket;
			hold_left <= LONG_HOLD;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			if (ready_mode_left == 0) begin
				ready_mode      <= $urandom_range(0, 3);
				ready_mode_left <= $urandom_range(20, 200);
			end else begin
				ready_mode_left <= ready_mode_left - 1;
			end
			case (ready_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic test_reset_defaults();
		lod_setting  = 8'(LOD_RESET);
		face_setting = FACE_BACK;
		send_point(8'd0, 8'd0);
		send_point(8'd8, 8'd8);
		send_point(8'd4, 8'd4);
		send_point(8'd255, 8'd0);
		wait_drained();
	endtask

	task automatic test_every_face();
		int f;
		for (f = 0; f < 8; f++) begin
			configure(8'd8, 3'(f), (f == 3) ? 5'b11111 : 5'b00000);
			send_point(8'd1, 8'd7);
			wait_drained();
		end
	endtask

	task automatic test_lod_extremes();
		configure(8'd1, FACE_FRONT, 5'd0);
		send_point(8'd0, 8'd1);
		send_point(8'd1, 8'd0);
		wait_drained();
		configure(8'd0, FACE_TOP, 5'd0);
		send_point(8'd0, 8'd0);
		send_point(8'd255, 8'd255);
		wait_drained();
		configure(8'd255, FACE_LEFT, 5'd0);
		send_point(8'd0, 8'd255);
		send_point(8'd255, 8'd0);
		send_point(8'd127, 8'd128);
		send_point(8'd128, 8'd127);
		wait_drained();
	endtask

	task automatic test_backpressure();
		configure(8'd16, FACE_RIGHT, 5'd0);
		sender_steady = 1'b1;
		hold_ticket <= hold_ticket + 1;
		repeat (24)
			send_point(8'($urandom_range(0, 16)), 8'($urandom_range(0, 16)));
		wait_drained();
		sender_steady = 1'b0;
		repeat (12)
			send_point(8'($urandom_range(0, 16)), 8'($urandom_range(0, 16)));
		wait_drained();
	endtask

	task automatic test_random_grid();
		int sent, phase_len, pick;
		logic [7:0] lod;
		logic [2:0] face;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				lod = 8'($urandom_range(0, 2));
			else if (pick < 8)
				lod = 8'($urandom_range(1, 24));
			else
				lod = 8'($urandom_range(25, 80));
			pick = $urandom_range(0, 15);
			if (pick == 14)
				face = FACE_SPARE_6;
			else if (pick == 15)
				face = FACE_SPARE_7;
			else
				face = 3'(pick % 6);
			configure(lod, face, 5'($urandom));
			sender_steady = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(30, 90);
			repeat (phase_len)
				send_point(random_index(lod), random_index(lod));
			sent += phase_len;
			wait_drained();
		end
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		m_tready        = 1'b0;
		mismatch_count  = 0;
		burst_left      = 0;
		sender_steady   = 1'b0;
		hold_ticket     = 0;
		hold_seen       = 0;
		hold_left       = 0;
		ready_mode      = 0;
		ready_mode_left = 0;
		idle_cycles     = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_every_face();
		test_lod_extremes();
		test_backpressure();
		test_random_grid();

		wait_drained();
		repeat (10) @(posedge clk);
		mismatch_count += expected_vertices.size();
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
